[src/lnqs_pkg.sv]
// Shared types and constants for the queued 4-bit character LCD writer.
package lnqs_pkg;

  localparam int QUEUE_DEPTH_DEF = 64;
  localparam int OPQ_DEPTH       = 4;

  // Item codes
  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_WRITE  = 2'd1,
    CMD_NIBBLE = 2'd2,
    CMD_POS    = 2'd3
  } lnqs_cmd_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_NUM_COLS  = 3'd0,
    CFG_NUM_ROWS  = 3'd1,
    CFG_ROW0_BASE = 3'd2,
    CFG_ROW1_BASE = 3'd3,
    CFG_ROW2_BASE = 3'd4,
    CFG_ROW3_BASE = 3'd5
  } lnqs_cfg_idx_t;

  localparam logic [6:0] NUM_COLS_RST  = 7'd20;
  localparam logic [2:0] NUM_ROWS_RST  = 3'd4;
  localparam logic [7:0] ROW0_BASE_RST = 8'h80;
  localparam logic [7:0] ROW1_BASE_RST = 8'hC0;
  localparam logic [7:0] ROW2_BASE_RST = 8'h94;
  localparam logic [7:0] ROW3_BASE_RST = 8'hD4;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] byte_value;
    logic       is_command;
    logic [5:0] column;
    logic [2:0] row;
  } lnqs_item_t;

  typedef struct packed {
    logic       reg_select;
    logic [3:0] data_nibble;
    logic       enable_pin;
    logic       position_error;
    logic       queue_overflow;
  } lnqs_result_t;

  // Queue entry: bit 4 command tag, bits 3..0 nibble
  typedef struct packed {
    logic       tick;
    logic [1:0] nent;
    logic [4:0] e0;
    logic [4:0] e1;
    logic       perr;
  } lnqs_op_t;

  typedef struct packed {
    logic fifo_empty;
    logic fifo_full;
  } lnqs_stat_t;

endpackage

[src/lcd_nibble_queue_strobe.sv]
// Top level of the queued 4-bit character LCD writer.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+----------------------------------------------
//  item     | item_valid / item_stall    | cmd, byte_value, is_command, column, row
//  result   | result_valid / result_stall| reg_select, data_nibble, enable_pin, errors
//  cfg      | cfg_valid / cfg_ready      | cfg_index (register number), cfg_data
//
//  One item per clock sustained unless item_stall or result_stall holds the flow;
//  every item yields exactly one result beat. The op queue is written at the item's
//  accepting edge, then the execute stage and then the result register load in turn.
//  Execute stage does at most two FIFO writes (one per bank) or one pop per cycle.
//  Reset (rst, synchronous) empties all queues, idles the strobe and drops all pins.
//  A stalled result backs up into the op queue; item_stall rises once it is full.
module lcd_nibble_queue_strobe #(
  parameter int QUEUE_DEPTH = lnqs_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  output logic                   item_stall,
  input  lnqs_pkg::lnqs_item_t   item,
  output logic                   result_valid,
  input  logic                   result_stall,
  output lnqs_pkg::lnqs_result_t result,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [2:0]             cfg_index,
  input  logic [7:0]             cfg_data
);
  import lnqs_pkg::*;

  lnqs_op_t   dec_op;
  lnqs_op_t   head_op;
  logic       opq_full;
  logic       head_valid;
  logic       head_pop;
  lnqs_stat_t stat;

  // registers always writable; software must write them only while idle (unenforced)
  assign cfg_ready  = 1'b1;
  assign item_stall = opq_full;

  // decode: split bytes into tagged nibbles, range-check positions
  lnqs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item),
    .op        (dec_op)
  );

  // decoupling queue; one beat in per accepted item
  lnqs_opq u_opq (
    .clk        (clk),
    .rst        (rst),
    .push       (item_valid),
    .push_op    (dec_op),
    .full       (opq_full),
    .pop        (head_pop),
    .head_valid (head_valid),
    .head_op    (head_op)
  );

  // execute: nibble FIFO, enable strobe phases, pin levels, result beat
  lnqs_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .op_valid     (head_valid),
    .op           (head_op),
    .op_pop       (head_pop),
    .result       (result),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .stat         (stat)
  );

`ifndef SYNTHESIS
  a_fifo_state: assert property (@(posedge clk) disable iff (rst)
    !(stat.fifo_empty && stat.fifo_full))
    else $error("nibble FIFO both empty and full");

  a_err_excl: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.position_error) |-> !result.queue_overflow)
    else $error("refused position also flagged overflow");

  a_rst_out: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result beat valid right after reset");
`endif

endmodule

[src/lnqs_front.sv]
// Front end: configuration registers and item decode into queue operations.
module lnqs_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  input  logic [2:0]          cfg_index,
  input  logic [7:0]          cfg_data,
  input  lnqs_pkg::lnqs_item_t item,
  output lnqs_pkg::lnqs_op_t   op
);
  import lnqs_pkg::*;

  logic [6:0] num_cols;
  logic [2:0] num_rows;
  logic [7:0] row_base [4];
  logic       pos_bad;
  logic [7:0] addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_cols    <= NUM_COLS_RST;
      num_rows    <= NUM_ROWS_RST;
      row_base[0] <= ROW0_BASE_RST;
      row_base[1] <= ROW1_BASE_RST;
      row_base[2] <= ROW2_BASE_RST;
      row_base[3] <= ROW3_BASE_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_NUM_COLS:  num_cols    <= cfg_data[6:0];
        CFG_NUM_ROWS:  num_rows    <= cfg_data[2:0];
        CFG_ROW0_BASE: row_base[0] <= cfg_data;
        CFG_ROW1_BASE: row_base[1] <= cfg_data;
        CFG_ROW2_BASE: row_base[2] <= cfg_data;
        CFG_ROW3_BASE: row_base[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  assign pos_bad = ({1'b0, item.column} >= num_cols) || (item.row >= num_rows) || item.row[2];
  assign addr    = row_base[item.row[1:0]] + {2'b00, item.column};

  always_comb begin
    op      = '0;
    op.tick = 1'b0;
    case (item.cmd)
      CMD_TICK: begin
        op.tick = 1'b1;
      end
      CMD_WRITE: begin
        op.nent = 2'd2;
        op.e0   = {item.is_command, item.byte_value[7:4]};
        op.e1   = {item.is_command, item.byte_value[3:0]};
      end
      CMD_NIBBLE: begin
        op.nent = 2'd1;
        op.e0   = {1'b1, item.byte_value[3:0]};
      end
      CMD_POS: begin
        op.perr = pos_bad;
        op.nent = pos_bad ? 2'd0 : 2'd2;
        op.e0   = {1'b1, addr[7:4]};
        op.e1   = {1'b1, addr[3:0]};
      end
      default: ;
    endcase
  end

endmodule

[src/lnqs_opq.sv]
// Short operation queue between the decode front and the execution back end.
module lnqs_opq (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  lnqs_pkg::lnqs_op_t push_op,
  output logic               full,
  input  logic               pop,
  output logic               head_valid,
  output lnqs_pkg::lnqs_op_t head_op
);
  import lnqs_pkg::*;

  localparam int PW = $clog2(OPQ_DEPTH);
  localparam int CW = $clog2(OPQ_DEPTH + 1);

  lnqs_op_t        slots [OPQ_DEPTH];
  logic [PW-1:0]   wp;
  logic [PW-1:0]   rp;
  logic [CW-1:0]   count;
  logic            do_push;
  logic            do_pop;

  assign full       = (count == CW'(OPQ_DEPTH));
  assign head_valid = (count != '0);
  assign head_op    = slots[rp];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (do_push) wp <= (wp == PW'(OPQ_DEPTH - 1)) ? '0 : wp + PW'(1);
      if (do_pop)  rp <= (rp == PW'(OPQ_DEPTH - 1)) ? '0 : rp + PW'(1);
      count <= count + CW'(do_push) - CW'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots[wp] <= push_op;
  end

endmodule

[src/lnqs_back.sv]
// Back end: nibble FIFO in two interleaved banks, strobe sequencer, pins and result register.
module lnqs_back #(
  parameter int QUEUE_DEPTH = lnqs_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  op_valid,
  input  lnqs_pkg::lnqs_op_t    op,
  output logic                  op_pop,
  output lnqs_pkg::lnqs_result_t result,
  output logic                  result_valid,
  input  logic                  result_stall,
  output lnqs_pkg::lnqs_stat_t  stat
);
  import lnqs_pkg::*;

  localparam int BankDepth = (QUEUE_DEPTH + 1) / 2;
  localparam int PtrSlots  = 2 * BankDepth;
  localparam int PW        = $clog2(PtrSlots);
  localparam int RowW      = (BankDepth > 1) ? $clog2(BankDepth) : 1;
  localparam int CntW      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_HIGH = 2'd1,
    PH_HOLD = 2'd2
  } phase_t;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == PW'(PtrSlots - 1)) ? '0 : p + PW'(1);
  endfunction

  function automatic logic [RowW-1:0] row_of(input logic [PW-1:0] p);
    row_of = RowW'(p >> 1);
  endfunction

  logic [4:0] bank0 [BankDepth];
  logic [4:0] bank1 [BankDepth];

  phase_t          phase, phase_next;
  logic [PW-1:0]   wp, rp, wp1, wp2;
  logic [CntW-1:0] count;
  logic            first_ok, second_ok, ovf, pop, drop;
  logic            s1_load, out_load;
  logic            s1_valid, s1_pop, s1_drop, s1_perr, s1_ovf;
  logic [4:0]      rd0, rd1, rd_entry;
  logic            rd_sel;
  logic            pin_rs, pin_en;
  logic [3:0]      pin_nib;
  logic            pin_rs_next, pin_en_next;
  logic [3:0]      pin_nib_next;
  logic            we0, we1;
  logic [RowW-1:0] wrow0, wrow1;
  logic [4:0]      wdat0, wdat1;

  assign out_load = s1_valid && (!result_valid || !result_stall);
  assign s1_load  = op_valid && (!s1_valid || out_load);
  assign op_pop   = s1_load;

  assign wp1 = ptr_inc(wp);
  assign wp2 = ptr_inc(wp1);

  assign first_ok  = !op.tick && (op.nent != 2'd0) && (count < CntW'(QUEUE_DEPTH));
  assign second_ok = !op.tick && (op.nent == 2'd2) && first_ok
                     && ((count + CntW'(1)) < CntW'(QUEUE_DEPTH));
  assign ovf       = !op.tick && (((op.nent != 2'd0) && !first_ok)
                     || ((op.nent == 2'd2) && !second_ok));
  assign pop       = op.tick && (phase == PH_IDLE) && (count != '0);
  assign drop      = op.tick && (phase == PH_HIGH);

  always_comb begin
    phase_next = phase;
    if (op.tick) begin
      case (phase)
        PH_IDLE: phase_next = pop ? PH_HIGH : PH_IDLE;
        PH_HIGH: phase_next = PH_HOLD;
        default: phase_next = PH_IDLE;
      endcase
    end
  end

  // first entry lands in bank wp[0], second in the other bank
  always_comb begin
    we0   = s1_load && ((first_ok && !wp[0]) || (second_ok && wp[0]));
    we1   = s1_load && ((first_ok && wp[0]) || (second_ok && !wp[0]));
    wrow0 = wp[0] ? row_of(wp1) : row_of(wp);
    wrow1 = wp[0] ? row_of(wp) : row_of(wp1);
    wdat0 = wp[0] ? op.e1 : op.e0;
    wdat1 = wp[0] ? op.e0 : op.e1;
  end

  always_ff @(posedge clk) begin
    if (we0) bank0[wrow0] <= wdat0;
    if (we1) bank1[wrow1] <= wdat1;
    if (s1_load && pop) begin
      rd0    <= bank0[row_of(rp)];
      rd1    <= bank1[row_of(rp)];
      rd_sel <= rp[0];
    end
  end

  assign rd_entry = rd_sel ? rd1 : rd0;

  always_comb begin
    pin_rs_next  = pin_rs;
    pin_nib_next = pin_nib;
    pin_en_next  = pin_en;
    if (s1_pop) begin
      pin_rs_next  = !rd_entry[4];
      pin_nib_next = rd_entry[3:0];
      pin_en_next  = 1'b1;
    end else if (s1_drop) begin
      pin_en_next  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      wp           <= '0;
      rp           <= '0;
      count        <= '0;
      s1_valid     <= 1'b0;
      result_valid <= 1'b0;
      pin_rs       <= 1'b0;
      pin_nib      <= '0;
      pin_en       <= 1'b0;
    end else begin
      if (s1_load) begin
        phase <= phase_next;
        wp    <= second_ok ? wp2 : (first_ok ? wp1 : wp);
        rp    <= pop ? ptr_inc(rp) : rp;
        count <= count + CntW'(first_ok) + CntW'(second_ok) - CntW'(pop);
      end
      if (s1_load)       s1_valid <= 1'b1;
      else if (out_load) s1_valid <= 1'b0;
      if (out_load) begin
        result_valid <= 1'b1;
        pin_rs       <= pin_rs_next;
        pin_nib      <= pin_nib_next;
        pin_en       <= pin_en_next;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_pop  <= pop;
      s1_drop <= drop;
      s1_perr <= op.perr;
      s1_ovf  <= ovf;
    end
    if (out_load) begin
      result.reg_select     <= pin_rs_next;
      result.data_nibble    <= pin_nib_next;
      result.enable_pin     <= pin_en_next;
      result.position_error <= s1_perr;
      result.queue_overflow <= s1_ovf;
    end
  end

  assign stat.fifo_empty = (count == '0);
  assign stat.fifo_full  = (count == CntW'(QUEUE_DEPTH));

endmodule
